FILE: design/false_color_map_defines.svh
// ----------------------------------------------------------------------------
// false_color_map_defines.svh
// Assertion macros for the false color map checker.
// ----------------------------------------------------------------------------
`ifndef FALSE_COLOR_MAP_DEFINES_SVH
`define FALSE_COLOR_MAP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define FCM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("false_color_map check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define FCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("false_color_map check failed");

`endif

FILE: design/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg
// Register indexes, map codes and segment codes of the false color map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcm_pkg;

    localparam int ADDR_BITS = 4;

    typedef logic [1:0] t_reg_idx;
    typedef logic [2:0] t_map_sel;
    typedef logic [2:0] t_seg;

    localparam t_reg_idx REG_LOWER = 2'd0;
    localparam t_reg_idx REG_UPPER = 2'd1;
    localparam t_reg_idx REG_MAP   = 2'd2;

    localparam t_map_sel MAP_SPECTRUM = 3'd0;
    localparam t_map_sel MAP_REVERSE  = 3'd1;
    localparam t_map_sel MAP_GREY     = 3'd2;
    localparam t_map_sel MAP_RED      = 3'd3;
    localparam t_map_sel MAP_GREEN    = 3'd4;
    localparam t_map_sel MAP_BLUE     = 3'd5;

    // rainbow segments; primaries use SEG_0 for the rise and SEG_1 for the fade
    localparam t_seg SEG_0 = 3'd0;
    localparam t_seg SEG_1 = 3'd1;
    localparam t_seg SEG_2 = 3'd2;
    localparam t_seg SEG_3 = 3'd3;
    localparam t_seg SEG_4 = 3'd4;
    localparam t_seg SEG_5 = 3'd5;

    localparam logic [7:0] CH_MAX = 8'hFF;

endpackage

FILE: design/false_color_map.sv
// ----------------------------------------------------------------------------
// false_color_map
// Maps a signed sample to an RGB color: the sample is placed between the
// lower and upper bound, scaled to a fraction t in 1/2^FRAC_BITS steps and
// looked up on the selected scale (spectrum, reverse rainbow, grey, or a red,
// green or blue primary). The block takes one item per clock while the output
// side accepts; an output stall holds every stage and loses nothing. An item
// passes a clamp stage, the restoring divider that forms t one quotient bit
// per pipeline stage, a segment stage, a scaling stage and an output stage.
// An upper bound at or below the lower bound gives black with range_error
// set. Write the bounds and map_select only while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module false_color_map import fcm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    output logic                   o_range_error
);

    localparam int QW   = FRAC_BITS + 1;
    localparam int NDIV = FRAC_BITS + 1;
    localparam int PW   = FRAC_BITS + 9;
    localparam logic [QW-1:0] ONE   = QW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] ROUND = PW'((1 << FRAC_BITS) - 1);

    // configuration
    logic [SAMPLE_BITS-1:0] r_lower;
    logic [SAMPLE_BITS-1:0] r_upper;
    t_map_sel               r_map;
    logic [SAMPLE_BITS-1:0] r_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r_map   <= MAP_SPECTRUM;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[ADDR_BITS-1:2])
                REG_LOWER: r_lower <= pwdata[SAMPLE_BITS-1:0];
                REG_UPPER: r_upper <= pwdata[SAMPLE_BITS-1:0];
                REG_MAP:   r_map   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_span <= r_upper - r_lower;
    end

    always_comb begin
        unique case (paddr[ADDR_BITS-1:2])
            REG_LOWER: prdata = 32'(r_lower);
            REG_UPPER: prdata = 32'(r_upper);
            REG_MAP:   prdata = 32'(r_map);
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // stage advance chain
    logic r_s0_vld;
    logic r_div_vld [NDIV];
    logic r_c1_vld;
    logic r_c2_vld;
    logic r_out_vld;

    logic            w_out_free;
    logic            w_c2_free;
    logic            w_c1_free;
    logic [NDIV-1:0] w_div_free;
    logic            w_s0_free;

    always_comb begin
        w_out_free             = !r_out_vld || i_ready;
        w_c2_free              = !r_c2_vld || w_out_free;
        w_c1_free              = !r_c1_vld || w_c2_free;
        w_div_free[NDIV-1]     = !r_div_vld[NDIV-1] || w_c1_free;
        for (int j = NDIV - 2; j >= 0; j--) begin
            w_div_free[j] = !r_div_vld[j] || w_div_free[j+1];
        end
        w_s0_free              = !r_s0_vld || w_div_free[0];
    end

    assign o_ready = w_s0_free;

    // stage 0: clamp sample into the range
    logic signed [SAMPLE_BITS-1:0] w_smp;
    logic signed [SAMPLE_BITS-1:0] w_lo;
    logic signed [SAMPLE_BITS-1:0] w_hi;
    logic [SAMPLE_BITS-1:0]        n_s0_num;
    logic                          n_s0_err;
    logic [SAMPLE_BITS-1:0]        r_s0_num;
    logic                          r_s0_err;

    assign w_smp    = $signed(i_sample);
    assign w_lo     = $signed(r_lower);
    assign w_hi     = $signed(r_upper);
    assign n_s0_err = !(w_hi > w_lo);

    always_comb begin
        priority if (w_smp <= w_lo) begin
            n_s0_num = '0;
        end else if (w_smp >= w_hi) begin
            n_s0_num = r_upper - r_lower;
        end else begin
            n_s0_num = i_sample - r_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_s0_free) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_free && i_valid) begin
            r_s0_num <= n_s0_num;
            r_s0_err <= n_s0_err;
        end
    end

    // divider: one quotient bit per stage
    logic [SAMPLE_BITS-1:0] r_div_rem [NDIV];
    logic [QW-1:0]          r_div_quo [NDIV];
    logic                   r_div_err [NDIV];

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        logic [SAMPLE_BITS:0]   w_cand;
        logic                   w_ge;
        logic [SAMPLE_BITS-1:0] n_rem;
        logic [QW-1:0]          n_quo;
        logic                   w_vin;
        logic                   w_ein;

        if (j == 0) begin : g_first
            assign w_cand = {1'b0, r_s0_num};
            assign n_quo  = QW'(w_ge);
            assign w_vin  = r_s0_vld;
            assign w_ein  = r_s0_err;
        end else begin : g_next
            assign w_cand = {r_div_rem[j-1], 1'b0};
            assign n_quo  = {r_div_quo[j-1][QW-2:0], w_ge};
            assign w_vin  = r_div_vld[j-1];
            assign w_ein  = r_div_err[j-1];
        end

        assign w_ge  = w_cand >= {1'b0, r_span};
        assign n_rem = w_ge ? SAMPLE_BITS'(w_cand - {1'b0, r_span})
                            : w_cand[SAMPLE_BITS-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[j] <= 1'b0;
            end else if (w_div_free[j]) begin
                r_div_vld[j] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_div_free[j] && w_vin) begin
                r_div_rem[j] <= n_rem;
                r_div_quo[j] <= n_quo;
                r_div_err[j] <= w_ein;
            end
        end
    end

    // stage C1: segment and ramp argument
    logic [QW-1:0]        w_t;
    logic [FRAC_BITS+3:0] w_six;
    logic [3:0]           w_kraw;
    logic [FRAC_BITS+1:0] w_two;
    logic [QW-1:0]        n_c1_arg;
    t_seg                 n_c1_seg;
    logic                 n_c1_blank;
    logic [QW-1:0]        r_c1_arg;
    t_seg                 r_c1_seg;
    logic                 r_c1_blank;
    logic                 r_c1_err;

    assign w_t    = r_div_quo[NDIV-1];
    assign w_six  = ({3'b000, w_t} << 2) + ({3'b000, w_t} << 1);
    assign w_kraw = w_six[FRAC_BITS+3:FRAC_BITS];
    assign w_two  = {w_t, 1'b0};

    always_comb begin
        n_c1_arg   = '0;
        n_c1_seg   = SEG_0;
        n_c1_blank = 1'b0;
        unique case (r_map)
            MAP_SPECTRUM, MAP_REVERSE: begin
                if (w_kraw > 4'(SEG_5)) begin
                    n_c1_seg = SEG_5;
                    n_c1_arg = ONE;
                end else begin
                    n_c1_seg = w_kraw[2:0];
                    n_c1_arg = {1'b0, w_six[FRAC_BITS-1:0]};
                end
            end
            MAP_GREY: begin
                n_c1_arg   = w_t;
                n_c1_blank = w_t[FRAC_BITS];
            end
            MAP_RED, MAP_GREEN, MAP_BLUE: begin
                priority if (w_two[FRAC_BITS+1]) begin
                    n_c1_blank = 1'b1;
                end else if (w_two[FRAC_BITS]) begin
                    n_c1_seg = SEG_1;
                    n_c1_arg = {1'b0, w_two[FRAC_BITS-1:0]};
                end else begin
                    n_c1_arg = w_two[FRAC_BITS:0];
                end
            end
            default: n_c1_blank = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
        end else if (w_c1_free) begin
            r_c1_vld <= r_div_vld[NDIV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c1_free && r_div_vld[NDIV-1]) begin
            r_c1_arg   <= n_c1_arg;
            r_c1_seg   <= n_c1_seg;
            r_c1_blank <= n_c1_blank;
            r_c1_err   <= r_div_err[NDIV-1];
        end
    end

    // stage C2: scale by 255, floor and ceiling
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_prod_c;
    logic [8:0]    w_up9;
    logic [8:0]    w_upc9;
    logic [7:0]    r_c2_up;
    logic [7:0]    r_c2_upc;
    t_seg          r_c2_seg;
    logic          r_c2_blank;
    logic          r_c2_err;

    assign w_prod   = {r_c1_arg, 8'h00} - PW'(r_c1_arg);
    assign w_prod_c = w_prod + ROUND;
    assign w_up9    = w_prod[PW-1:FRAC_BITS];
    assign w_upc9   = w_prod_c[PW-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_vld <= 1'b0;
        end else if (w_c2_free) begin
            r_c2_vld <= r_c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c2_free && r_c1_vld) begin
            r_c2_up    <= w_up9[8] ? CH_MAX : w_up9[7:0];
            r_c2_upc   <= w_upc9[8] ? CH_MAX : w_upc9[7:0];
            r_c2_seg   <= r_c1_seg;
            r_c2_blank <= r_c1_blank;
            r_c2_err   <= r_c1_err;
        end
    end

    // output stage: assemble channels
    logic [7:0] w_dn;
    logic [7:0] w_prim;
    logic [7:0] w_other;
    logic [7:0] n_red;
    logic [7:0] n_green;
    logic [7:0] n_blue;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic       r_err;

    assign w_dn    = ~r_c2_upc;
    assign w_prim  = (r_c2_seg == SEG_1) ? CH_MAX : r_c2_up;
    assign w_other = (r_c2_seg == SEG_1) ? r_c2_upc : 8'h00;

    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        if (!r_c2_blank && !r_c2_err) begin
            unique case (r_map)
                MAP_SPECTRUM: begin
                    unique case (r_c2_seg)
                        SEG_0: begin n_red = r_c2_up; n_blue = r_c2_up; end
                        SEG_1: begin n_red = w_dn; n_blue = CH_MAX; end
                        SEG_2: begin n_green = r_c2_up; n_blue = w_dn; end
                        SEG_3: begin n_red = r_c2_up; n_green = CH_MAX; end
                        SEG_4: begin n_red = CH_MAX; n_green = w_dn; end
                        default: begin
                            n_red   = CH_MAX;
                            n_green = r_c2_up;
                            n_blue  = r_c2_up;
                        end
                    endcase
                end
                MAP_REVERSE: begin
                    unique case (r_c2_seg)
                        SEG_0: begin n_red = CH_MAX; n_green = w_dn; n_blue = w_dn; end
                        SEG_1: begin n_red = CH_MAX; n_green = r_c2_up; end
                        SEG_2: begin n_red = w_dn; n_green = CH_MAX; end
                        SEG_3: begin n_green = w_dn; n_blue = r_c2_up; end
                        SEG_4: begin n_red = r_c2_up; n_blue = CH_MAX; end
                        default: begin n_red = w_dn; n_blue = w_dn; end
                    endcase
                end
                MAP_GREY: begin
                    n_red   = r_c2_up;
                    n_green = r_c2_up;
                    n_blue  = r_c2_up;
                end
                MAP_RED: begin
                    n_red   = w_prim;
                    n_green = w_other;
                    n_blue  = w_other;
                end
                MAP_GREEN: begin
                    n_red   = w_other;
                    n_green = w_prim;
                    n_blue  = w_other;
                end
                MAP_BLUE: begin
                    n_red   = w_other;
                    n_green = w_other;
                    n_blue  = w_prim;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_c2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_c2_vld) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_err   <= r_c2_err;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_range_error = r_err;

endmodule

FILE: design/fcm_chk.sv
// ----------------------------------------------------------------------------
// fcm_chk
// Port-level checks of the false color map, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "false_color_map_defines.svh"

module fcm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_ready,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_range_error
);

    // hold a stalled item
    `FCM_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_range_error))

    // an empty or draining output slot frees the whole pipeline
    `FCM_ASSERT_NOW(a_ready_free, !o_valid || i_ready, o_ready)

    // an empty range gives black
    `FCM_ASSERT_NOW(a_err_black, o_valid && o_range_error, (o_red == 8'h00) && (o_green == 8'h00) && (o_blue == 8'h00))

endmodule

bind false_color_map fcm_chk u_fcm_chk (.*);

FILE: bench/false_color_map_tb.sv
// ----------------------------------------------------------------------------
// false_color_map_tb
// Streams signed samples through the false color map under a series of
// bound and map settings written over APB, predicts each RGB item and the
// range error flag in the bench, and compares every output item in order.
// In the randomized part, both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module false_color_map_tb;
    import fcm_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int FRAC_ONE    = 1 << FRAC_BITS;
    localparam int PIPE_DEPTH  = FRAC_BITS + 5;
    localparam int SETTLE      = PIPE_DEPTH + 8;
    localparam int RAND_ITEMS  = 900;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       range_error;
    } color_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_BITS-1:0]   paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   i_valid;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   o_valid;
    logic                   i_ready;
    logic [7:0]             o_red;
    logic [7:0]             o_green;
    logic [7:0]             o_blue;
    logic                   o_range_error;

    false_color_map #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_range_error(o_range_error)
    );

    logic signed [15:0]     cfg_lower;
    logic signed [15:0]     cfg_upper;
    t_map_sel               cfg_map;

    logic [SAMPLE_BITS-1:0] sample_q[$];
    color_t                 color_q[$];
    int                     errors;
    logic                   in_fire;
    int                     send_gap;
    int                     sink_stall;
    bit                     src_idle_on;
    bit                     sink_idle_on;

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] ramp_up(input longint f);
        longint v;
        v = (f * 255) / FRAC_ONE;
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function automatic logic [7:0] ramp_up_ceil(input longint f);
        longint v;
        v = (f * 255 + FRAC_ONE - 1) / FRAC_ONE;
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function automatic logic [7:0] ramp_down(input longint f);
        return CH_MAX - ramp_up_ceil(f);
    endfunction

    function automatic color_t map_color(input logic signed [15:0] s,
                                         input logic signed [15:0] lo,
                                         input logic signed [15:0] hi,
                                         input t_map_sel sel);
        color_t     c;
        longint     d, num, t, w, k, f;
        logic [7:0] prim, other;
        c = '0;
        if (hi <= lo) begin
            c.range_error = 1'b1;
        end else begin
            d   = longint'(hi) - longint'(lo);
            num = (s <= lo) ? 0 : (s >= hi) ? d : longint'(s) - longint'(lo);
            t   = (num * FRAC_ONE) / d;
            case (sel)
                MAP_SPECTRUM, MAP_REVERSE: begin
                    w = t * 6;
                    k = w / FRAC_ONE;
                    if (k > 5) k = 5;
                    f = w - k * FRAC_ONE;
                    if (sel == MAP_SPECTRUM) begin
                        case (t_seg'(k))
                            SEG_0: begin c.red = ramp_up(f); c.blue = ramp_up(f); end
                            SEG_1: begin c.red = ramp_down(f); c.blue = CH_MAX; end
                            SEG_2: begin c.green = ramp_up(f); c.blue = ramp_down(f); end
                            SEG_3: begin c.red = ramp_up(f); c.green = CH_MAX; end
                            SEG_4: begin c.red = CH_MAX; c.green = ramp_down(f); end
                            default: begin
                                c.red   = CH_MAX;
                                c.green = ramp_up(f);
                                c.blue  = ramp_up(f);
                            end
                        endcase
                    end else begin
                        case (t_seg'(k))
                            SEG_0: begin
                                c.red   = CH_MAX;
                                c.green = ramp_down(f);
                                c.blue  = ramp_down(f);
                            end
                            SEG_1: begin c.red = CH_MAX; c.green = ramp_up(f); end
                            SEG_2: begin c.red = ramp_down(f); c.green = CH_MAX; end
                            SEG_3: begin c.green = ramp_down(f); c.blue = ramp_up(f); end
                            SEG_4: begin c.red = ramp_up(f); c.blue = CH_MAX; end
                            default: begin c.red = ramp_down(f); c.blue = ramp_down(f); end
                        endcase
                    end
                end
                MAP_GREY: begin
                    if (t < FRAC_ONE) begin
                        c.red   = ramp_up(t);
                        c.green = c.red;
                        c.blue  = c.red;
                    end
                end
                MAP_RED, MAP_GREEN, MAP_BLUE: begin
                    w     = t * 2;
                    prim  = '0;
                    other = '0;
                    if (w < FRAC_ONE) begin
                        prim = ramp_up(w);
                    end else if (w < 2 * FRAC_ONE) begin
                        prim  = CH_MAX;
                        other = ramp_up_ceil(w - FRAC_ONE);
                    end
                    c.red   = (sel == MAP_RED)   ? prim : other;
                    c.green = (sel == MAP_GREEN) ? prim : other;
                    c.blue  = (sel == MAP_BLUE)  ? prim : other;
                end
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_sample(input logic signed [15:0] lo,
                                                input logic signed [15:0] hi);
        longint v;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 30 || hi <= lo) begin
            v = longint'($urandom_range(0, 65535)) - 32768;
        end else if (r < 70) begin
            v = longint'(lo) - 2 + $urandom_range(0, int'(longint'(hi) - longint'(lo) + 4));
        end else if (r < 85) begin
            v = longint'(lo) - 3 + $urandom_range(0, 6);
        end else begin
            v = longint'(hi) - 3 + $urandom_range(0, 6);
        end
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[15:0];
    endfunction

    // driver: advance to the next sample once the current item is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (sample_q.size() != 0) begin
                i_valid  <= 1'b1;
                i_sample <= sample_q.pop_front();
                send_gap <= src_idle_on ? pick_gap() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready    <= 1'b1;
            sink_stall <= (sink_idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        end
    end

    // monitor: predict on input items, compare on output items
    always @(posedge i_clk) begin
        color_t want;
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            color_q.push_back(map_color(i_sample, cfg_lower, cfg_upper, cfg_map));
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (color_q.size() == 0) begin
                $error("unexpected output item");
                errors++;
            end else begin
                want = color_q.pop_front();
                if (o_red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_red);
                    errors++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_green);
                    errors++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_blue);
                    errors++;
                end
                if (o_range_error !== want.range_error) begin
                    $error("range_error: expected %0d, got %0d",
                           want.range_error, o_range_error);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value, input int bits);
        logic [31:0] mask;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) !== (value & mask)) begin
            $error("register %0d: expected %0h, got %0h", idx, value & mask, prdata & mask);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input logic signed [15:0] lo, input logic signed [15:0] hi,
                                input t_map_sel sel);
        reg_write(REG_LOWER, {{16{lo[15]}}, lo}, 16);
        cfg_lower = lo;
        reg_write(REG_UPPER, {{16{hi[15]}}, hi}, 16);
        cfg_upper = hi;
        reg_write(REG_MAP, {29'd0, sel}, 3);
        cfg_map = sel;
    endtask

    // hold until every item has gone through, then let the pipeline drain
    task automatic drain();
        while (sample_q.size() != 0 || i_valid || color_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_samples(input logic [15:0] vals[]);
        foreach (vals[i]) sample_q.push_back(vals[i]);
    endtask

    initial begin
        logic signed [15:0] lo, hi;
        longint             base, span;
        int                 sent, n;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_sample     = '0;
        in_fire      = 1'b0;
        errors       = 0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        cfg_lower    = 16'sd0;
        cfg_upper    = 16'sd32767;
        cfg_map      = MAP_SPECTRUM;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings, full-scale and mid-scale samples
        push_samples('{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'h7FFE});
        drain();
        apply_config(-16'sd32768, 16'sd32767, MAP_REVERSE);
        push_samples('{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
        drain();
        apply_config(16'sd5, 16'sd5, MAP_SPECTRUM);
        push_samples('{16'h0005, 16'h8000});
        drain();
        apply_config(16'sd100, -16'sd100, MAP_GREEN);
        push_samples('{16'h0000});
        drain();
        apply_config(16'sd0, 16'sd12, MAP_GREY);
        push_samples('{16'h0000, 16'h0006, 16'h000C});
        drain();
        apply_config(16'sd0, 16'sd2, MAP_RED);
        push_samples('{16'h0000, 16'h0001, 16'h0002});
        drain();
        apply_config(16'sd0, 16'sd2, MAP_GREEN);
        push_samples('{16'h0001});
        drain();
        apply_config(16'sd0, 16'sd2, MAP_BLUE);
        push_samples('{16'h0001});
        drain();
        apply_config(16'sd0, 16'sd12, t_map_sel'(6));
        push_samples('{16'h0006});
        drain();
        apply_config(16'sd0, 16'sd12, t_map_sel'(7));
        push_samples('{16'h0006});
        drain();

        sent = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    lo = -16'sd32768;
                    hi = 16'sd32767;
                end
                1: begin
                    lo = 16'($urandom_range(0, 65535));
                    hi = ($urandom_range(0, 1) == 0) ? lo
                                                     : 16'(lo - $urandom_range(1, 300));
                    if (hi > lo) hi = lo;
                end
                2, 3, 4, 5: begin
                    span = $urandom_range(1, 24);
                    base = longint'($urandom_range(0, 65535)) - 32768;
                    if (base + span > 32767) base = 32767 - span;
                    lo = 16'(base);
                    hi = 16'(base + span);
                end
                default: begin
                    lo = 16'($urandom_range(0, 65535));
                    hi = 16'($urandom_range(0, 65535));
                    if (hi < lo) {lo, hi} = {hi, lo};
                end
            endcase
            apply_config(lo, hi, t_map_sel'($urandom_range(0, 7)));
            src_idle_on  = ($urandom_range(0, 9) < 7);
            sink_idle_on = ($urandom_range(0, 9) < 7);
            n = $urandom_range(10, 35);
            repeat (n) sample_q.push_back(pick_sample(cfg_lower, cfg_upper));
            sent += n;
            drain();
        end

        if (color_q.size() != 0) begin
            $error("%0d output items never arrived", color_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
